// File: sv/cfpb_pkg.sv
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared types, constants and the CRC byte update of the packet builder.
// ----------------------------------------------------------------------------
package cfpb_pkg;

    // Fixed field widths
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int SEQ_W  = 16;
    localparam int POS_W  = 6;

    // CRC-16/CCITT-FALSE
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // Byte steps of the serializer
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HDR0   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SEQ_LO = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SEQ_HI = 4'd3;
    localparam logic [STEP_W-1:0] STEP_W0     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_W1     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_W2     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_W3     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd9;

    // One classified word
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first;
        logic              last;
    } t_cmd;

    // Back end status seen by the top-level checks
    typedef struct packed {
        logic              busy;
        logic              produce;
        logic              last;
        logic [STEP_W-1:0] step;
        logic [1:0]        out_cnt;
    } t_back_stat;

    // Fold one byte into the CRC, msb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: sv/cfpb_front.sv
// ----------------------------------------------------------------------------
// cfpb_front
// Accepts words and tags each with its place in the packet.
// ----------------------------------------------------------------------------
module cfpb_front #(
    parameter int WORDS_PER_PACKET = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic [cfpb_pkg::WORD_W-1:0] i_joint_word,
    output logic                      o_we,
    output cfpb_pkg::t_cmd            o_cmd
);
    import cfpb_pkg::*;

    // Packets hold between 2 and 63 words
    localparam int WORDS_EFF = (WORDS_PER_PACKET < 2) ? 2 :
                               ((WORDS_PER_PACKET > 63) ? 63 : WORDS_PER_PACKET);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORDS_EFF - 1);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             accept;
    logic             is_last;

    assign accept  = i_push && !i_full;
    assign is_last = (r_pos == POS_LAST);

    // Classify the incoming word
    assign o_we       = accept;
    assign o_cmd.word = i_joint_word;
    assign o_cmd.first = (r_pos == '0);
    assign o_cmd.last  = is_last;

    // Advance the word position, wrap at packet end
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = is_last ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// File: sv/cfpb_cmdq.sv
// ----------------------------------------------------------------------------
// cfpb_cmdq
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module cfpb_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  cfpb_pkg::t_cmd i_cmd,
    input  logic           i_re,
    output cfpb_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import cfpb_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_we && !o_full;
    assign do_rd   = i_re && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/cfpb_back.sv
// ----------------------------------------------------------------------------
// cfpb_back
// Serializes each word into bytes, adds header and CRC, buffers the output.
// ----------------------------------------------------------------------------
module cfpb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cfpb_pkg::BYTE_W-1:0] i_sync_first,
    input  logic [cfpb_pkg::BYTE_W-1:0] i_sync_second,
    input  cfpb_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_re,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [cfpb_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_packet_end,
    output cfpb_pkg::t_back_stat        o_stat
);
    import cfpb_pkg::*;

    logic              r_busy;
    t_cmd              r_cmd;
    logic [STEP_W-1:0] r_step;
    logic [CRC_W-1:0]  r_crc;
    logic [SEQ_W-1:0]  r_seq;

    logic [BYTE_W-1:0] r_obyte [2];
    logic              r_oend  [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_ocnt;

    logic [BYTE_W-1:0] cur_byte;
    logic [CRC_W-1:0]  crc_in;
    logic [CRC_W-1:0]  crc_nx;
    logic              last_step;
    logic              pop_acc;
    logic              produce;
    logic              load;

    // Pick the byte of the current step
    always_comb begin
        case (r_step)
            STEP_HDR0:   cur_byte = i_sync_first;
            STEP_HDR1:   cur_byte = i_sync_second;
            STEP_SEQ_LO: cur_byte = r_seq[7:0];
            STEP_SEQ_HI: cur_byte = r_seq[15:8];
            STEP_W0:     cur_byte = r_cmd.word[7:0];
            STEP_W1:     cur_byte = r_cmd.word[15:8];
            STEP_W2:     cur_byte = r_cmd.word[23:16];
            STEP_W3:     cur_byte = r_cmd.word[31:24];
            STEP_CRC_LO: cur_byte = r_crc[7:0];
            STEP_CRC_HI: cur_byte = r_crc[15:8];
            default:     cur_byte = '0;
        endcase
    end

    // CRC restarts on the sequence low byte
    assign crc_in = (r_step == STEP_SEQ_LO) ? CRC_INIT : r_crc;
    assign crc_nx = crc_byte(crc_in, cur_byte);

    assign last_step = ((r_step == STEP_W3) && !r_cmd.last) || (r_step == STEP_CRC_HI);
    assign pop_acc   = i_pop && !o_empty;
    assign produce   = r_busy && ((r_ocnt != 2'd2) || pop_acc);
    assign load      = !i_cmd_empty && (!r_busy || (produce && last_step));
    assign o_cmd_re  = load;

    // Step through the bytes of one word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_W0;
            r_seq  <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_step <= i_cmd.first ? STEP_HDR0 : STEP_W0;
            end else if (produce) begin
                if (last_step) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (produce && (r_step == STEP_SEQ_HI)) begin
                r_seq <= r_seq + 1'b1;
            end
        end
    end

    // Hold the word and the running CRC
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (produce && (r_step inside {[STEP_SEQ_LO:STEP_W3]})) begin
            r_crc <= crc_nx;
        end
    end

    // Two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_obyte[r_wp] <= cur_byte;
            r_oend[r_wp]  <= (r_step == STEP_CRC_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (produce) begin
                r_wp <= ~r_wp;
            end
            if (pop_acc) begin
                r_rp <= ~r_rp;
            end
            if (produce && !pop_acc) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (pop_acc && !produce) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    assign o_empty      = (r_ocnt == '0);
    assign o_out_byte   = r_obyte[r_rp];
    assign o_packet_end = r_oend[r_rp];

    assign o_stat.busy    = r_busy;
    assign o_stat.produce = produce;
    assign o_stat.last    = r_cmd.last;
    assign o_stat.step    = r_step;
    assign o_stat.out_cnt = r_ocnt;

endmodule

// File: sv/crc_framed_packet_builder.sv
// ----------------------------------------------------------------------------
// crc_framed_packet_builder
// Frames groups of 32-bit words into byte packets with header, sequence
// number and CRC-16/CCITT-FALSE.
//
// Usage:
//   Input queue: drive i_joint_word with push; the word is taken when full is
//   low. Output queue: while empty is low, o_out_byte / o_packet_end show the
//   oldest byte; pop takes it. o_packet_end marks the CRC high byte.
//   Config: i_cfg_we writes i_cfg_data into sync byte i_cfg_idx; write only
//   while the block is idle.
//   Throughput: one byte per cycle out of the serializer while the output
//   buffer has room; a word is 4 bytes, 8 for the first word of a packet
//   (header and sequence) and 6 for the last (CRC), so a packet of N words
//   is 4*N+6 bytes. When the block is idle, a pushed word passes through the
//   command queue and the serializer before its first byte shows on the output.
//   A four-word command queue lets the input run ahead of the serializer;
//   full rises when it fills. When pop stays low the two-byte output buffer
//   fills, the serializer halts and the command queue backs up.
//   Reset clears both queues, the word position and the sequence number and
//   restores the sync bytes to 0xAA and 0x55.
// ----------------------------------------------------------------------------
module crc_framed_packet_builder #(
    parameter int WORDS_PER_PACKET = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [cfpb_pkg::WORD_W-1:0]    i_joint_word,
    output logic                           empty,
    input  logic                           pop,
    output logic [cfpb_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_packet_end,
    input  logic                           i_cfg_we,
    input  logic [cfpb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfpb_pkg::BYTE_W-1:0]    i_cfg_data
);
    import cfpb_pkg::*;

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;

    logic       front_we;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    logic       q_empty;
    logic       q_re;
    t_back_stat back_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                REG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    cfpb_front #(
        .WORDS_PER_PACKET(WORDS_PER_PACKET)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_joint_word (i_joint_word),
        .o_we         (front_we),
        .o_cmd        (front_cmd)
    );

    cfpb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (front_we),
        .i_cmd   (front_cmd),
        .i_re    (q_re),
        .o_cmd   (q_cmd),
        .o_full  (full),
        .o_empty (q_empty)
    );

    cfpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_cmd         (q_cmd),
        .i_cmd_empty   (q_empty),
        .o_cmd_re      (q_re),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_packet_end  (o_packet_end),
        .o_stat        (back_stat)
    );

    // Output buffer never overflows
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(back_stat.produce && (back_stat.out_cnt == 2'd2) && !(pop && !empty)))
        else $error("output buffer overflow");

    // CRC bytes only follow the last word of a packet
    a_crc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_stat.busy && ((back_stat.step == STEP_CRC_LO) ||
                            (back_stat.step == STEP_CRC_HI))) |-> back_stat.last)
        else $error("CRC step outside last word");

    // A CRC high byte produced while the output is empty shows up flagged as packet end
    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_stat.produce && (back_stat.step == STEP_CRC_HI) && empty)
        |=> (!empty && o_packet_end))
        else $error("packet end flag lost");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CRC framed packet builder. A short directed
// list of words opens the run, then random words are sent in several phases
// with different header bytes and different amounts of idling on the input
// and output sides. A predictor in the bench frames every accepted word and
// queues the expected bytes; every popped byte is compared with the oldest.
// ----------------------------------------------------------------------------
module testbench;

    import cfpb_pkg::*;

    // Words per packet as the block sees it, clamped to the legal range
    localparam int PKT_WORDS_CFG = 14;
    localparam int PKT_WORDS =
        (PKT_WORDS_CFG < 2) ? 2 : ((PKT_WORDS_CFG > 63) ? 63 : PKT_WORDS_CFG);

    localparam int N_DIRECTED     = 25;
    localparam int N_PHASES       = 5;
    localparam int WORDS_PER_PASS = 64;
    localparam int STALL_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 16;

    // One byte of a packet as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pkt_end;
    } t_pkt_byte;

    // Directed word; typed bytes are in send order, first byte at the top
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [3:0]        n_typed;
        logic [63:0]       typed;
    } t_dir_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  push         = 1'b0;
    logic                  full;
    logic [WORD_W-1:0]     i_joint_word = '0;
    logic                  empty;
    logic                  pop          = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_packet_end;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = REG_SYNC_FIRST;
    logic [BYTE_W-1:0]     i_cfg_data   = '0;

    // Predictor state
    logic [BYTE_W-1:0]     hdr_first  = SYNC_FIRST_RST;
    logic [BYTE_W-1:0]     hdr_second = SYNC_SECOND_RST;
    logic [SEQ_W-1:0]      pkt_seq    = '0;
    logic [CRC_W-1:0]      pkt_crc    = CRC_INIT;
    logic [POS_W-1:0]      pkt_pos    = '0;

    t_pkt_byte             framed_bytes[$];
    t_pkt_byte             pending_bytes[$];
    t_pkt_byte             oldest;

    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    n_errors       = 0;
    int                    quiet_cycles   = 0;

    t_dir_row directed_rows [0:N_DIRECTED-1] = '{
        '{32'hFFFF_FFFF, 4'd8, 64'hAA55_0000_FFFF_FFFF},
        '{32'h0000_0000, 4'd4, 64'h0000_0000_0000_0000},
        '{32'h1234_5678, 4'd4, 64'h7856_3412_0000_0000},
        '{32'h8000_0000, 4'd4, 64'h0000_0080_0000_0000},
        '{32'h0000_0001, 4'd4, 64'h0100_0000_0000_0000},
        '{32'h7FFF_FFFF, 4'd0, 64'h0},
        '{32'hFFFF_FFFE, 4'd0, 64'h0},
        '{32'hA5A5_A5A5, 4'd0, 64'h0},
        '{32'h5A5A_5A5A, 4'd0, 64'h0},
        '{32'h0000_FFFF, 4'd0, 64'h0},
        '{32'hFFFF_0000, 4'd0, 64'h0},
        '{32'hDEAD_BEEF, 4'd0, 64'h0},
        '{32'h0102_0304, 4'd0, 64'h0},
        '{32'hFFFF_FFFF, 4'd0, 64'h0},
        '{32'h0000_0000, 4'd8, 64'hAA55_0100_0000_0000},
        '{32'hFFFF_FFFF, 4'd0, 64'h0},
        '{32'h0F0F_0F0F, 4'd0, 64'h0},
        '{32'hF0F0_F0F0, 4'd0, 64'h0},
        '{32'h00FF_00FF, 4'd0, 64'h0},
        '{32'hFF00_FF00, 4'd0, 64'h0},
        '{32'h8000_0001, 4'd0, 64'h0},
        '{32'h0000_0000, 4'd0, 64'h0},
        '{32'h1111_1111, 4'd0, 64'h0},
        '{32'hCAFE_F00D, 4'd0, 64'h0},
        '{32'h3333_CCCC, 4'd0, 64'h0}
    };

    crc_framed_packet_builder #(
        .WORDS_PER_PACKET(PKT_WORDS_CFG)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_joint_word (i_joint_word),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shift one byte through the CRC register, data msb first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = r[CRC_W-1] ^ data[i];
            r  = {r[CRC_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Frame one word: fill framed_bytes and advance the packet state
    function automatic void frame_word(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] b;
        framed_bytes.delete();
        if (pkt_pos == '0) begin
            pkt_crc = CRC_INIT;
            framed_bytes.push_back('{hdr_first, 1'b0});
            framed_bytes.push_back('{hdr_second, 1'b0});
            for (int k = 0; k < 2; k++) begin
                b = pkt_seq[8*k +: 8];
                framed_bytes.push_back('{b, 1'b0});
                pkt_crc = crc_fold(pkt_crc, b);
            end
            pkt_seq = pkt_seq + 1'b1;
        end
        for (int k = 0; k < 4; k++) begin
            b = w[8*k +: 8];
            framed_bytes.push_back('{b, 1'b0});
            pkt_crc = crc_fold(pkt_crc, b);
        end
        pkt_pos = pkt_pos + 1'b1;
        if (int'(pkt_pos) >= PKT_WORDS) begin
            framed_bytes.push_back('{pkt_crc[7:0], 1'b0});
            framed_bytes.push_back('{pkt_crc[15:8], 1'b1});
            pkt_pos = '0;
            pkt_crc = CRC_INIT;
        end
    endfunction

    // Random word, biased toward corner patterns
    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] one_hot;
        one_hot = 32'h1 << $urandom_range(WORD_W - 1);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            4:       return {4{8'($urandom)}};
            default: return $urandom;
        endcase
    endfunction

    // Send one word, idling first at random; queue its expected bytes
    task automatic send_word(input logic [WORD_W-1:0] w, input logic [3:0] n_typed,
                             input logic [63:0] typed);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_joint_word <= w;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        frame_word(w);
        if (n_typed != 0) begin
            for (int k = 0; k < n_typed; k++) begin
                pending_bytes.push_back('{typed[63-8*k -: 8], 1'b0});
            end
        end else begin
            foreach (framed_bytes[k]) begin
                pending_bytes.push_back(framed_bytes[k]);
            end
        end
    endtask

    // Hold the input until every expected byte has been popped
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write both header bytes; block must be idle
    task automatic load_sync_bytes(input logic [BYTE_W-1:0] first_b,
                                   input logic [BYTE_W-1:0] second_b);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SYNC_FIRST;
        i_cfg_data <= first_b;
        @(posedge i_clk);
        hdr_first  = first_b;
        i_cfg_idx  <= REG_SYNC_SECOND;
        i_cfg_data <= second_b;
        @(posedge i_clk);
        hdr_second = second_b;
        i_cfg_we   <= 1'b0;
    endtask

    // Output side: pop with the stall rate of the current phase
    always @(posedge i_clk) begin
        pop <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every popped byte with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected byte: out_byte=%02h packet_end=%0d",
                       o_out_byte, o_packet_end);
                n_errors++;
            end else begin
                oldest = pending_bytes.pop_front();
                if (o_out_byte !== oldest.data) begin
                    $error("out_byte: expected %02h, got %02h", oldest.data, o_out_byte);
                    n_errors++;
                end
                if (o_packet_end !== oldest.pkt_end) begin
                    $error("packet_end: expected %0d, got %0d",
                           oldest.pkt_end, o_packet_end);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int sender_pct [N_PHASES];
        int stall_pct  [N_PHASES];
        sender_pct = '{0, 84, 0, 27, 0};
        stall_pct  = '{0, 0, 84, 27, 0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words with the reset header bytes
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_word(directed_rows[r].word, directed_rows[r].n_typed,
                      directed_rows[r].typed);
        end
        wait_drained();

        // Random phases, each with new header bytes and its own idling
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       load_sync_bytes(8'h00, 8'hFF);
                1:       load_sync_bytes(8'hFF, 8'h00);
                default: load_sync_bytes(8'($urandom), 8'($urandom));
            endcase
            send_idle_pct  = sender_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int i = 0; i < WORDS_PER_PASS; i++) begin
                // pause mid-phase until the output side has caught up
                if (i == WORDS_PER_PASS / 2) begin
                    wait_drained();
                end
                send_word(rand_word(), 4'd0, 64'h0);
            end
            wait_drained();
        end

        // Let any stray bytes show up before the verdict
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
